@@ sv/codel_pkg.sv @@
package codel_pkg;

  localparam int TimeBitsDefault = 40;
  localparam int SumBits = 56;
  localparam int CntBits = 32;
  localparam int WsumBits = 40;
  localparam int ThrBits = 32;
  localparam int BetaBits = 32;
  localparam int WinBits = 8;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_FAST = 2'd1;
  localparam logic [1:0] OP_SLOW = 2'd2;
  localparam logic [1:0] OP_RESET = 2'd3;

  localparam logic [2:0] EV_SAMPLE = 3'd0;
  localparam logic [2:0] EV_NO_DATA = 3'd1;
  localparam logic [2:0] EV_VIOL = 3'd2;
  localparam logic [2:0] EV_NO_VIOL = 3'd3;
  localparam logic [2:0] EV_INACTIVE = 3'd4;
  localparam logic [2:0] EV_SKIPPED = 3'd5;
  localparam logic [2:0] EV_MEASURED = 3'd6;

  localparam logic [2:0] REG_INIT_IVL = 3'd0;
  localparam logic [2:0] REG_MIN_TGT = 3'd1;
  localparam logic [2:0] REG_MAX_TGT = 3'd2;
  localparam logic [2:0] REG_STEP = 3'd3;
  localparam logic [2:0] REG_BETA = 3'd4;
  localparam logic [2:0] REG_WINDOW = 3'd5;
  localparam logic [2:0] REG_ACTIVE = 3'd6;

  localparam logic [29:0] NS_PER_S = 30'd1000000000;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } codel_div_ctl_t;

endpackage

@@ sv/codel_divider.sv @@
module codel_divider
  import codel_pkg::*;
#(
  parameter int NumBits = 64,
  parameter int DenBits = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NumBits-1:0] num,
  input  logic [DenBits-1:0] den,
  output codel_div_ctl_t     ctl,
  output logic [NumBits-1:0] quo
);

  localparam int CntW = $clog2(NumBits + 1);

  logic [NumBits-1:0] num_r, num_nxt;
  logic [NumBits-1:0] quo_r, quo_nxt;
  logic [DenBits:0]   rem_r, rem_nxt;
  logic [DenBits-1:0] den_r, den_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DenBits:0]   shifted;

  // restoring division, one quotient bit per cycle
  always_comb begin
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted = {rem_r[DenBits-1:0], num_r[NumBits-1]};
    if (start) begin
      num_nxt = num;
      den_nxt = den;
      rem_nxt = '0;
      quo_nxt = '0;
      cnt_nxt = CntW'(NumBits);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = shifted - {1'b0, den_r};
        quo_nxt = {quo_r[NumBits-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[NumBits-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CntW'(1);
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign ctl.start = start;
  assign ctl.busy = busy_r;
  assign ctl.done = done_r;
  assign quo = quo_r;

endmodule

@@ sv/codel_adaptive_target_controller.sv @@
// CoDel-style delay controller with adaptive target latency.
// Input channel in_*: one item per handshake (in_valid high, in_stall low).
// in_operation selects sample, fast tick, slow tick or reset; one result per item.
// Output channel out_*: out_valid holds a result until out_stall is low.
// Samples, fast ticks without a violation, skipped slow ticks and resets
// put their result in the output register in the cycle after acceptance.
// A fast tick with a violation runs a 17-step square root and a 128-step
// divide before its result is ready.
// A measured slow tick runs a 30-step shift-add multiply (bytes * 1e9), a
// 128-step throughput divide, an optional 128-step base or beta divide and
// a 128-step average divide. With zero elapsed time the multiply and
// throughput divide are skipped.
// One item is in flight at a time; in_stall is high while an item is
// being processed or its result waits in the output register.
// Reset (rst_n low, synchronous) loads register defaults and clears state.
// While out_stall is high a pending result holds, and with it no new item is taken.
// cfg_*: APB-style register port, 64-bit data, registers at 8*index.
module codel_adaptive_target_controller
  import codel_pkg::*;
#(
  parameter int TIME_BITS = TimeBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_operation,
  input  logic [TIME_BITS-1:0] in_latency_ns,
  input  logic [31:0]          in_size_bytes,
  input  logic [TIME_BITS-1:0] in_elapsed_ns,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_event_res,
  output logic [TIME_BITS-1:0] out_next_interval_ns,
  output logic [TIME_BITS-1:0] out_target_latency_ns,
  output logic [31:0]          out_throughput_q8,
  output logic [TIME_BITS-1:0] out_avg_latency_ns,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [5:0]           cfg_paddr,
  input  logic [63:0]          cfg_pwdata,
  output logic [63:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int TB = TIME_BITS;
  localparam int DivBits = 128;
  localparam logic [TB-1:0] TimeMax = {TB{1'b1}};
  localparam logic [TB-1:0] Fallback = TB'(1000);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SQRT = 4'd1;
  localparam logic [3:0] S_IVL = 4'd2;
  localparam logic [3:0] S_MUL = 4'd3;
  localparam logic [3:0] S_THR = 4'd4;
  localparam logic [3:0] S_BASE = 4'd5;
  localparam logic [3:0] S_BETA = 4'd6;
  localparam logic [3:0] S_FIN = 4'd7;
  localparam logic [3:0] S_AVG = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;

  // configuration
  logic [TB-1:0] init_ivl_r, min_tgt_r, max_tgt_r, step_r;
  logic [31:0]   beta_r;
  logic [7:0]    win_r;
  logic          active_r;
  logic [2:0]    cfg_idx;
  logic          cfg_wr;

  assign cfg_idx = cfg_paddr[5:3];
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      REG_INIT_IVL: cfg_prdata = 64'(init_ivl_r);
      REG_MIN_TGT:  cfg_prdata = 64'(min_tgt_r);
      REG_MAX_TGT:  cfg_prdata = 64'(max_tgt_r);
      REG_STEP:     cfg_prdata = 64'(step_r);
      REG_BETA:     cfg_prdata = 64'(beta_r);
      REG_WINDOW:   cfg_prdata = 64'(win_r);
      REG_ACTIVE:   cfg_prdata = 64'(active_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_ivl_r <= TB'(100000000);
      min_tgt_r <= TB'(5000000);
      max_tgt_r <= TB'(100000000);
      step_r <= TB'(1000000);
      beta_r <= 32'd256;
      win_r <= 8'd10;
      active_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_INIT_IVL: init_ivl_r <= cfg_pwdata[TB-1:0];
        REG_MIN_TGT:  min_tgt_r <= cfg_pwdata[TB-1:0];
        REG_MAX_TGT:  max_tgt_r <= cfg_pwdata[TB-1:0];
        REG_STEP:     step_r <= cfg_pwdata[TB-1:0];
        REG_BETA:     beta_r <= cfg_pwdata[31:0];
        REG_WINDOW:   win_r <= cfg_pwdata[7:0];
        REG_ACTIVE:   active_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // state
  logic [3:0]    st_r, st_nxt;
  logic [TB-1:0] min_lat_r, min_lat_nxt;
  logic          min_vld_r, min_vld_nxt;
  logic [31:0]   vcnt_r, vcnt_nxt;
  logic [TB-1:0] ivl_r, ivl_nxt;
  logic [55:0]   lsum_r, lsum_nxt;
  logic [31:0]   scnt_r, scnt_nxt;
  logic [55:0]   bsum_r, bsum_nxt;
  logic          started_r, started_nxt;
  logic          calib_r, calib_nxt;
  logic [39:0]   wsum_r, wsum_nxt;
  logic [7:0]    wcnt_r, wcnt_nxt;
  logic [31:0]   base_r, base_nxt;
  logic [TB-1:0] tgt_r, tgt_nxt;
  logic [31:0]   thr_r, thr_nxt;
  logic [TB-1:0] avg_r, avg_nxt;
  logic          ovld_r, ovld_nxt;
  logic [2:0]    ev_r, ev_nxt;

  // working registers
  logic [16:0]   sq_r, sq_nxt;
  logic [4:0]    sqi_r, sqi_nxt;
  logic [85:0]   mcand_r, mcand_nxt;
  logic [TB-1:0] el_r, el_nxt;
  logic [6:0]    mi_r, mi_nxt;
  logic [95:0]   prod_r, prod_nxt;
  logic [63:0]   lsum_hold_r, lsum_hold_nxt;
  logic [31:0]   cnt_hold_r, cnt_hold_nxt;
  logic [31:0]   cur_r, cur_nxt;
  logic [TB:0]   t_r, t_nxt;

  // divider
  logic               dv_start;
  logic [DivBits-1:0] dv_num;
  logic [DivBits-1:0] dv_den;
  codel_div_ctl_t     dv_ctl;
  logic [DivBits-1:0] dv_quo;

  codel_divider #(.NumBits(DivBits), .DenBits(DivBits)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(dv_start),
    .num  (dv_num),
    .den  (dv_den),
    .ctl  (dv_ctl),
    .quo  (dv_quo)
  );

  logic          in_acc;
  logic [32:0]   sq_t;
  logic [65:0]   sq_sq;
  logic [56:0]   lsum_add, bsum_add;
  logic [32:0]   cnt_add;
  logic [40:0]   wsum_add;
  logic [7:0]    wcnt_inc;
  logic [TB:0]   tt;
  logic [33:0]   r_sq;

  assign in_acc = in_valid & ~in_stall;
  assign in_stall = (st_r != S_IDLE) | ovld_r;

  always_comb begin
    st_nxt = st_r;
    min_lat_nxt = min_lat_r;
    min_vld_nxt = min_vld_r;
    vcnt_nxt = vcnt_r;
    ivl_nxt = ivl_r;
    lsum_nxt = lsum_r;
    scnt_nxt = scnt_r;
    bsum_nxt = bsum_r;
    started_nxt = started_r;
    calib_nxt = calib_r;
    wsum_nxt = wsum_r;
    wcnt_nxt = wcnt_r;
    base_nxt = base_r;
    tgt_nxt = tgt_r;
    thr_nxt = thr_r;
    avg_nxt = avg_r;
    ovld_nxt = ovld_r;
    ev_nxt = ev_r;
    sq_nxt = sq_r;
    sqi_nxt = sqi_r;
    mcand_nxt = mcand_r;
    el_nxt = el_r;
    mi_nxt = mi_r;
    prod_nxt = prod_r;
    lsum_hold_nxt = lsum_hold_r;
    cnt_hold_nxt = cnt_hold_r;
    cur_nxt = cur_r;
    t_nxt = t_r;
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = '0;
    sq_t = '0;
    sq_sq = '0;
    lsum_add = '0;
    bsum_add = '0;
    cnt_add = '0;
    wsum_add = '0;
    wcnt_inc = '0;
    tt = '0;
    r_sq = '0;

    if (ovld_r && !out_stall) begin
      ovld_nxt = 1'b0;
    end

    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_operation)
            OP_SAMPLE: begin
              if (!min_vld_r || in_latency_ns < min_lat_r) begin
                min_lat_nxt = in_latency_ns;
                min_vld_nxt = 1'b1;
              end
              lsum_add = 57'(lsum_r) + 57'(in_latency_ns);
              lsum_nxt = lsum_add[56] ? '1 : lsum_add[55:0];
              cnt_add = 33'(scnt_r) + 33'd1;
              scnt_nxt = cnt_add[32] ? '1 : cnt_add[31:0];
              bsum_add = 57'(bsum_r) + 57'(in_size_bytes);
              bsum_nxt = bsum_add[56] ? '1 : bsum_add[55:0];
              ev_nxt = EV_SAMPLE;
              ovld_nxt = 1'b1;
            end
            OP_FAST: begin
              if (!min_vld_r) begin
                ev_nxt = EV_NO_DATA;
                ovld_nxt = 1'b1;
              end else if (!active_r) begin
                ev_nxt = EV_INACTIVE;
                min_vld_nxt = 1'b0;
                ovld_nxt = 1'b1;
              end else if (min_lat_r > tgt_r) begin
                cnt_add = 33'(vcnt_r) + 33'd1;
                vcnt_nxt = cnt_add[32] ? '1 : cnt_add[31:0];
                min_vld_nxt = 1'b0;
                sq_nxt = '0;
                sqi_nxt = 5'd16;
                ev_nxt = EV_VIOL;
                st_nxt = S_SQRT;
              end else begin
                vcnt_nxt = '0;
                ivl_nxt = init_ivl_r;
                min_vld_nxt = 1'b0;
                ev_nxt = EV_NO_VIOL;
                ovld_nxt = 1'b1;
              end
            end
            OP_SLOW: begin
              started_nxt = 1'b1;
              bsum_nxt = '0;
              lsum_nxt = '0;
              scnt_nxt = '0;
              if (started_r && scnt_r != '0) begin
                ev_nxt = EV_MEASURED;
                lsum_hold_nxt = 64'(lsum_r);
                cnt_hold_nxt = scnt_r;
                el_nxt = in_elapsed_ns;
                if (in_elapsed_ns == '0) begin
                  cur_nxt = (bsum_r != '0) ? '1 : '0;
                  st_nxt = S_FIN;
                end else begin
                  // bytes * 1e9, shift-add one bit per cycle
                  prod_nxt = '0;
                  mcand_nxt = 86'(bsum_r);
                  mi_nxt = 7'd0;
                  t_nxt = '0;
                  st_nxt = S_MUL;
                end
              end else begin
                ev_nxt = EV_SKIPPED;
                ovld_nxt = 1'b1;
              end
            end
            default: begin
              ivl_nxt = init_ivl_r;
              tgt_nxt = min_tgt_r;
              min_vld_nxt = 1'b0;
              bsum_nxt = '0;
              started_nxt = 1'b0;
              calib_nxt = 1'b1;
              wsum_nxt = '0;
              wcnt_nxt = '0;
              ev_nxt = EV_MEASURED;
              ovld_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SQRT: begin
        sq_t = 33'(sq_r | (17'd1 << sqi_r));
        sq_sq = 66'(sq_t) * 66'(sq_t);
        if (sq_sq <= 66'(vcnt_r)) begin
          sq_nxt = sq_t[16:0];
        end
        if (sqi_r == 5'd0) begin
          st_nxt = S_IVL;
        end else begin
          sqi_nxt = sqi_r - 5'd1;
        end
      end
      S_IVL: begin
        if (!dv_ctl.busy && !dv_ctl.done) begin
          r_sq = 34'(sq_r) * 34'(sq_r) + 34'(sq_r);
          if (34'(vcnt_r) > r_sq) begin
            dv_den = DivBits'(sq_r) + DivBits'(1);
          end else begin
            dv_den = DivBits'(sq_r);
          end
          dv_num = DivBits'(init_ivl_r);
          dv_start = 1'b1;
        end else if (dv_ctl.done) begin
          if (dv_quo[TB-1:0] == '0) begin
            ivl_nxt = Fallback;
          end else begin
            ivl_nxt = dv_quo[TB-1:0];
          end
          ovld_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        if (NS_PER_S[mi_r[4:0]]) begin
          prod_nxt = prod_r + 96'(mcand_r);
        end
        mcand_nxt = mcand_r << 1;
        if (mi_r == 7'd29) begin
          st_nxt = S_THR;
        end else begin
          mi_nxt = mi_r + 7'd1;
        end
      end
      S_THR: begin
        if (!dv_ctl.busy && !dv_ctl.done) begin
          dv_num = DivBits'(prod_r);
          dv_den = DivBits'(el_r) << 12;
          dv_start = 1'b1;
        end else if (dv_ctl.done) begin
          cur_nxt = (dv_quo[DivBits-1:32] != '0) ? '1 : dv_quo[31:0];
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        wcnt_inc = (wcnt_r < 8'd255) ? wcnt_r + 8'd1 : wcnt_r;
        wcnt_nxt = wcnt_inc;
        wsum_add = 41'(wsum_r) + 41'(cur_r);
        wsum_nxt = wsum_add[40] ? '1 : wsum_add[39:0];
        thr_nxt = cur_r;
        t_nxt = {1'b0, tgt_r};
        if (calib_r) begin
          t_nxt = {1'b0, min_tgt_r};
          if (wcnt_inc >= win_r) begin
            st_nxt = S_BASE;
          end else begin
            st_nxt = S_AVG;
          end
        end else if (wcnt_inc >= win_r && cur_r > base_r) begin
          st_nxt = S_BETA;
        end else begin
          st_nxt = S_AVG;
        end
      end
      S_BASE: begin
        if (!dv_ctl.busy && !dv_ctl.done) begin
          dv_num = DivBits'(wsum_r);
          dv_den = DivBits'(wcnt_r);
          dv_start = 1'b1;
        end else if (dv_ctl.done) begin
          base_nxt = dv_quo[31:0];
          calib_nxt = 1'b0;
          wsum_nxt = '0;
          wcnt_nxt = '0;
          t_nxt = (TB+1)'(min_tgt_r) + (TB+1)'(step_r);
          st_nxt = S_AVG;
        end
      end
      S_BETA: begin
        if (beta_r == '0) begin
          t_nxt = (TB+1)'(min_tgt_r) + (TB+1)'(TimeMax);
          wsum_nxt = '0;
          wcnt_nxt = '0;
          st_nxt = S_AVG;
        end else if (!dv_ctl.busy && !dv_ctl.done) begin
          dv_num = DivBits'(cur_r - base_r);
          dv_den = DivBits'(beta_r);
          dv_start = 1'b1;
        end else if (dv_ctl.done) begin
          t_nxt = (TB+1)'(min_tgt_r) + (TB+1)'(dv_quo[31:0]);
          wsum_nxt = '0;
          wcnt_nxt = '0;
          st_nxt = S_AVG;
        end
      end
      S_AVG: begin
        if (!dv_ctl.busy && !dv_ctl.done) begin
          dv_num = DivBits'(lsum_hold_r);
          dv_den = DivBits'(cnt_hold_r);
          dv_start = 1'b1;
        end else if (dv_ctl.done) begin
          avg_nxt = dv_quo[TB-1:0];
          tt = t_r;
          if (tt < (TB+1)'(min_tgt_r)) tt = (TB+1)'(min_tgt_r);
          if (tt > (TB+1)'(max_tgt_r)) tt = (TB+1)'(max_tgt_r);
          tgt_nxt = tt[TB-1:0];
          ovld_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
    sq_r <= sq_nxt;
    sqi_r <= sqi_nxt;
    mcand_r <= mcand_nxt;
    el_r <= el_nxt;
    mi_r <= mi_nxt;
    prod_r <= prod_nxt;
    lsum_hold_r <= lsum_hold_nxt;
    cnt_hold_r <= cnt_hold_nxt;
    cur_r <= cur_nxt;
    t_r <= t_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE;
      min_vld_r <= 1'b0;
      started_r <= 1'b0;
      calib_r <= 1'b1;
      ovld_r <= 1'b0;
      min_lat_r <= '0;
      vcnt_r <= '0;
      ivl_r <= TB'(100000000);
      lsum_r <= '0;
      scnt_r <= '0;
      bsum_r <= '0;
      wsum_r <= '0;
      wcnt_r <= '0;
      base_r <= '0;
      tgt_r <= TB'(5000000);
      thr_r <= '0;
      avg_r <= '0;
    end else begin
      st_r <= st_nxt;
      min_vld_r <= min_vld_nxt;
      started_r <= started_nxt;
      calib_r <= calib_nxt;
      ovld_r <= ovld_nxt;
      min_lat_r <= min_lat_nxt;
      vcnt_r <= vcnt_nxt;
      ivl_r <= ivl_nxt;
      lsum_r <= lsum_nxt;
      scnt_r <= scnt_nxt;
      bsum_r <= bsum_nxt;
      wsum_r <= wsum_nxt;
      wcnt_r <= wcnt_nxt;
      base_r <= base_nxt;
      tgt_r <= tgt_nxt;
      thr_r <= thr_nxt;
      avg_r <= avg_nxt;
    end
  end

  assign out_valid = ovld_r;
  assign out_event_res = ev_r;
  assign out_next_interval_ns = ivl_r;
  assign out_target_latency_ns = tgt_r;
  assign out_throughput_q8 = thr_r;
  assign out_avg_latency_ns = avg_r;

endmodule

@@ sv/codel_checker.sv @@
module codel_checker
  import codel_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_event_res
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_res))
    else $error("result dropped under stall");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_res != 3'd7)
    else $error("bad event code");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind codel_adaptive_target_controller codel_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_event_res(out_event_res)
);

@@ bench/testbench.sv @@
module testbench
  import codel_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [39:0] TMASK = 40'hFF_FFFF_FFFF;
  localparam logic [55:0] SUM_LIM = {56{1'b1}};
  localparam logic [39:0] WSUM_LIM = {40{1'b1}};

  typedef struct packed {
    logic [1:0] op;
    logic [39:0] lat;
    logic [31:0] size;
    logic [39:0] elapsed;
  } item_t;

  typedef struct packed {
    logic [2:0] ev;
    logic [39:0] ivl;
    logic [39:0] tgt;
    logic [31:0] thr;
    logic [39:0] avg;
  } res_t;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic [1:0] in_operation = 0;
  logic [39:0] in_latency_ns = 0, in_elapsed_ns = 0;
  logic [31:0] in_size_bytes = 0;
  logic [2:0] out_event_res;
  logic [39:0] out_next_interval_ns, out_target_latency_ns, out_avg_latency_ns;
  logic [31:0] out_throughput_q8;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [5:0] cfg_paddr = 0;
  logic [63:0] cfg_pwdata = 0, cfg_prdata;
  logic cfg_pready;

  codel_adaptive_target_controller dut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  // controller registers and state
  logic [63:0] r_init, r_min, r_max, r_step, r_beta, r_win, r_act;
  logic [63:0] min_lat, vcount, fivl, lsum, scount, bsum;
  logic [63:0] wsum, wticks, base_thr, tgt, last_thr, last_avg;
  logic min_ok, slow_go, calib;

  item_t pending[$];
  res_t expected_res[$];
  int errors = 0;
  bit quiet = 0;

  function automatic logic [63:0] sat_add(logic [63:0] a, b, lim);
    logic [64:0] s;
    s = a + b;
    return (s > lim) ? lim : s[63:0];
  endfunction

  function automatic logic [63:0] rsqrt(logic [63:0] c);
    logic [63:0] r;
    r = 0;
    for (int b = 16; b >= 0; b--)
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= c) r = r | (64'd1 << b);
    if (c > r * r + r) r++;
    return r;
  endfunction

  function automatic logic [63:0] thr_of(logic [63:0] bytes, elapsed);
    logic [127:0] num, q;
    if (elapsed == 0) return bytes != 0 ? 64'hFFFF_FFFF : 0;
    num = 128'(bytes) * 128'd1000000000;
    q = num / (128'(elapsed) << 12);
    return (q > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : q[63:0];
  endfunction

  task automatic regs_default();
    r_init = 100000000; r_min = 5000000; r_max = 100000000; r_step = 1000000;
    r_beta = 256; r_win = 10; r_act = 1;
    min_lat = 0; min_ok = 0; vcount = 0; fivl = r_init; lsum = 0; scount = 0;
    bsum = 0; slow_go = 0; calib = 1; wsum = 0; wticks = 0; base_thr = 0;
    tgt = r_min; last_thr = 0; last_avg = 0;
  endtask

  function automatic res_t predict_step(item_t it);
    res_t r;
    logic [63:0] cur, t, d;
    case (it.op)
      OP_SAMPLE: begin
        if (!min_ok || it.lat < min_lat) begin
          min_lat = it.lat; min_ok = 1;
        end
        lsum = sat_add(lsum, it.lat, SUM_LIM);
        scount = sat_add(scount, 1, 64'hFFFF_FFFF);
        bsum = sat_add(bsum, it.size, SUM_LIM);
        r.ev = EV_SAMPLE;
      end
      OP_FAST: begin
        if (!min_ok) r.ev = EV_NO_DATA;
        else begin
          if (!r_act[0]) r.ev = EV_INACTIVE;
          else if (min_lat > tgt) begin
            vcount = sat_add(vcount, 1, 64'hFFFF_FFFF);
            fivl = r_init / rsqrt(vcount);
            if (fivl == 0) fivl = 1000;
            r.ev = EV_VIOL;
          end else begin
            vcount = 0; fivl = r_init; r.ev = EV_NO_VIOL;
          end
          min_ok = 0;
        end
      end
      OP_SLOW: begin
        if (slow_go && scount > 0) begin
          cur = thr_of(bsum, it.elapsed);
          t = tgt;
          if (wticks < 255) wticks++;
          wsum = sat_add(wsum, cur, WSUM_LIM);
          if (calib) begin
            t = r_min;
            if (wticks >= r_win) begin
              calib = 0; base_thr = wsum / wticks; wsum = 0; wticks = 0;
              t = t + r_step;
            end
          end else if (wticks >= r_win && cur > base_thr) begin
            d = cur - base_thr;
            t = r_min + (r_beta != 0 ? d / r_beta : TMASK);
            wsum = 0; wticks = 0;
          end
          if (t < r_min) t = r_min;
          if (t > r_max) t = r_max;
          tgt = t & TMASK; last_thr = cur; last_avg = (lsum / scount) & TMASK;
          r.ev = EV_MEASURED;
        end else r.ev = EV_SKIPPED;
        slow_go = 1; bsum = 0; lsum = 0; scount = 0;
      end
      default: begin
        fivl = r_init; tgt = r_min; min_ok = 0; bsum = 0; slow_go = 0;
        calib = 1; wsum = 0; wticks = 0; r.ev = EV_MEASURED;
      end
    endcase
    r.ivl = fivl[39:0]; r.tgt = tgt[39:0]; r.thr = last_thr[31:0];
    r.avg = last_avg[39:0];
    return r;
  endfunction

  // driver
  int gap = 0;
  logic in_stall_q;
  int stall_left = 0;
  bit accepted_in = 0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_q) begin
        if (gap == 0 && pending.size() > 0 && !quiet && $urandom_range(5) == 0)
          gap = $urandom_range(1, 6);
      end
      if (!in_valid || accepted_in) begin
        if (gap > 0) begin
          gap--; in_valid <= 0;
        end else if (pending.size() > 0) begin
          item_t it;
          it = pending.pop_front();
          in_valid <= 1; in_operation <= it.op; in_latency_ns <= it.lat;
          in_size_bytes <= it.size; in_elapsed_ns <= it.elapsed;
          if (!quiet && $urandom_range(7) == 0) gap = $urandom_range(1, 6);
        end else in_valid <= 0;
      end
      out_stall <= !quiet && (($urandom_range(5) == 0) || (stall_left > 0));
    end
  end

  always @(posedge clk) begin
    in_stall_q <= in_stall;
    accepted_in <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      expected_res.push_back(predict_step('{in_operation, in_latency_ns,
                                             in_size_bytes, in_elapsed_ns}));
    if (stall_left > 0) stall_left <= stall_left - 1;
    else if (!quiet && $urandom_range(15) == 0) stall_left <= $urandom_range(1, 6);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      res_t got, want;
      got = '{out_event_res, out_next_interval_ns, out_target_latency_ns,
              out_throughput_q8, out_avg_latency_ns};
      if (expected_res.size() == 0) begin
        errors++;
        $display("%0t unexpected result, expected none, actual %p", $time, got);
      end else begin
        want = expected_res.pop_front();
        if (got.ev !== want.ev) begin
          errors++; $display("%0t event: expected %0d actual %0d", $time, want.ev, got.ev);
        end
        if (got.ivl !== want.ivl) begin
          errors++; $display("%0t interval: expected %0d actual %0d", $time, want.ivl, got.ivl);
        end
        if (got.tgt !== want.tgt) begin
          errors++; $display("%0t target: expected %0d actual %0d", $time, want.tgt, got.tgt);
        end
        if (got.thr !== want.thr) begin
          errors++; $display("%0t throughput: expected %0d actual %0d", $time, want.thr, got.thr);
        end
        if (got.avg !== want.avg) begin
          errors++; $display("%0t avg latency: expected %0d actual %0d", $time, want.avg, got.avg);
        end
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= {idx, 3'b000}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_INIT_IVL: r_init = val & TMASK;
      REG_MIN_TGT: r_min = val & TMASK;
      REG_MAX_TGT: r_max = val & TMASK;
      REG_STEP: r_step = val & TMASK;
      REG_BETA: r_beta = val & 64'hFFFF_FFFF;
      REG_WINDOW: r_win = val & 64'hFF;
      default: r_act = val & 1;
    endcase
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || expected_res.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [39:0] rnd40();
    case ($urandom_range(3))
      0: return 40'({$urandom, $urandom}) & TMASK;
      1: return 40'($urandom_range(0, 200000000));
      2: return 40'($urandom_range(0, 20));
      default: return $urandom_range(0, 1) ? TMASK : 40'd0;
    endcase
  endfunction

  task automatic push(logic [1:0] op, logic [39:0] lat, logic [31:0] sz,
                      logic [39:0] el);
    pending.push_back('{op, lat, sz, el});
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      int k;
      k = $urandom_range(99);
      if (k < 60)
        push(OP_SAMPLE, $urandom_range(1) ? 40'($urandom_range(0, 120000000)) : rnd40(),
             $urandom_range(3) == 0 ? $urandom : $urandom_range(0, 1 << 20), rnd40());
      else if (k < 78) push(OP_FAST, rnd40(), $urandom, rnd40());
      else if (k < 96)
        push(OP_SLOW, rnd40(), $urandom,
             $urandom_range(3) == 0 ? rnd40() : 40'($urandom_range(1, 2000000)));
      else push(OP_RESET, rnd40(), $urandom, rnd40());
    end
  endtask

  initial begin
    regs_default();
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1;
    // directed
    push(OP_FAST, 0, 0, 0);
    push(OP_SLOW, 0, 0, 0);
    push(OP_SAMPLE, TMASK, 32'hFFFF_FFFF, TMASK);
    push(OP_SAMPLE, 0, 0, 0);
    push(OP_FAST, 0, 0, 0);
    push(OP_SAMPLE, TMASK, 32'hFFFF_FFFF, 0);
    push(OP_FAST, 0, 0, 0);
    push(OP_SAMPLE, 200000000, 1000, 0);
    push(OP_FAST, 0, 0, 0);
    push(OP_SLOW, 0, 0, 0);
    push(OP_SLOW, 0, 0, 5);
    push(OP_SAMPLE, 50, 32'hFFFF_FFFF, 0);
    push(OP_SLOW, 0, 0, 1);
    push(OP_SAMPLE, 50, 0, 0);
    push(OP_SLOW, 0, 0, 0);
    push(OP_SAMPLE, 7, 12345, 0);
    push(OP_SLOW, 0, 0, TMASK);
    push(OP_RESET, TMASK, 32'hFFFF_FFFF, TMASK);
    drain();
    cfg_write(REG_ACTIVE, 0);
    push(OP_SAMPLE, 3, 3, 3);
    push(OP_FAST, 0, 0, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_ACTIVE, 1); cfg_write(REG_WINDOW, 1); cfg_write(REG_BETA, 0);
        end
        1: begin
          cfg_write(REG_INIT_IVL, 0); cfg_write(REG_MIN_TGT, TMASK);
          cfg_write(REG_MAX_TGT, 0); cfg_write(REG_STEP, TMASK);
        end
        2: begin
          cfg_write(REG_INIT_IVL, TMASK); cfg_write(REG_MIN_TGT, 0);
          cfg_write(REG_MAX_TGT, TMASK); cfg_write(REG_BETA, 32'hFFFF_FFFF);
          cfg_write(REG_WINDOW, 255); cfg_write(REG_STEP, 0);
        end
        3: begin
          cfg_write(REG_WINDOW, 0); cfg_write(REG_BETA, 1); cfg_write(REG_INIT_IVL, 1);
        end
        4: begin
          cfg_write(REG_INIT_IVL, 100000000); cfg_write(REG_MIN_TGT, 5000000);
          cfg_write(REG_MAX_TGT, 100000000); cfg_write(REG_STEP, 1000000);
          cfg_write(REG_BETA, 256); cfg_write(REG_WINDOW, 3);
        end
        default: begin
          cfg_write(REG_WINDOW, $urandom_range(1, 8)); cfg_write(REG_ACTIVE, 1);
          cfg_write(REG_BETA, $urandom_range(1, 4096));
        end
      endcase
      if (ph == 5) quiet = 1;
      random_phase(ph == 5 ? 100 : 90);
      drain();
    end
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ filelist.f @@
sv/codel_pkg.sv
sv/codel_divider.sv
sv/codel_adaptive_target_controller.sv
sv/codel_checker.sv
bench/testbench.sv
